FILE: design/rlpi_pkg.sv
// rlpi_pkg: shared types, constants and helpers for the rotated line /
// parabola intersection pipeline. No dependencies; imported by every module.

package rlpi_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // register map
  localparam logic [2:0] REG_RADIUS = 3'd0;
  localparam logic [2:0] REG_COS    = 3'd1;
  localparam logic [2:0] REG_SIN    = 3'd2;
  localparam logic [2:0] REG_COEF_A = 3'd3;
  localparam logic [2:0] REG_COEF_B = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NEG_DISC = 2'd1;
  localparam logic [1:0] ST_ZERO_A   = 2'd2;
  localparam logic [1:0] ST_SAT      = 2'd3;

  localparam logic signed [31:0] INT32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

  // cell datapath widths
  localparam int ROOT_W    = 32;  // sqrt result bits, one per cell
  localparam int SQ_REM_W  = 35;
  localparam int RAD_W     = 64;
  localparam int Q_W       = 32;  // quotient bits, one per cell
  localparam int DIV_REM_W = 33;
  localparam int DEN_W     = 33;

  typedef struct packed {
    logic signed [31:0] radius;
    logic signed [15:0] cos_theta;
    logic signed [15:0] sin_theta;
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
  } cfg_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } sat_t;

  // sideband that rides along the cell chains
  typedef struct packed {
    logic               bypass;   // result already final (pi/2, zero A, neg disc)
    logic [1:0]         st;
    logic signed [31:0] y_early;
    logic               neg;      // quotient sign
    logic               ovf;      // |quotient| >= 2^32
  } side_t;

  typedef struct packed {
    side_t              base;
    logic signed [31:0] bb;
    logic signed [31:0] ac;
  } sq_side_t;

  function automatic sat_t sat32(input logic signed [71:0] v);
    sat_t r;
    if (v > 72'(INT32_MAX)) begin
      r.clip = 1'b1;
      r.val  = INT32_MAX;
    end else if (v < 72'(INT32_MIN)) begin
      r.clip = 1'b1;
      r.val  = INT32_MIN;
    end else begin
      r.clip = 1'b0;
      r.val  = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: design/rlpi_front.sv
// rlpi_front: eight-stage fixed-point front end forming D, A, B, C and the
// quarter discriminant E. Depends on rlpi_pkg.

module rlpi_front import rlpi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               take,
  input  logic signed [31:0] x_pos,
  input  cfg_t               cfg,
  output logic               sq_valid,
  output logic [RAD_W-1:0]   sq_rad,
  output sq_side_t           sq_side
);

  localparam int CF_L = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
  localparam int CF_R = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;

  logic [7:1] v;
  logic [7:1] pi;

  // stage 1
  logic signed [32:0] xr_w, xr1;
  logic signed [47:0] as_w, as1, rs_w, xs_w;
  logic signed [63:0] xx_w, xx1;
  logic signed [33:0] rs1, xs1;

  assign xr_w = 33'(x_pos) + 33'(cfg.radius);
  assign as_w = cfg.coef_a * cfg.sin_theta;
  assign xx_w = x_pos * x_pos;
  assign rs_w = cfg.radius * cfg.sin_theta;
  assign xs_w = x_pos * cfg.sin_theta;

  always_ff @(posedge clk) begin
    if (en) begin
      xr1 <= xr_w;
      as1 <= as_w;
      xx1 <= xx_w;
      rs1 <= rs_w[47:14];
      xs1 <= xs_w[47:14];
    end
  end

  // stage 2
  logic signed [48:0] dp_w;
  logic signed [34:0] dsh;
  logic signed [63:0] acp_w;
  logic signed [35:0] acsh;
  logic signed [33:0] psh;
  logic signed [63:0] qxsh;
  logic signed [34:0] rsxs_w;
  sat_t d_s, ac_s, p_s, qx_s;
  logic signed [31:0] d2, ac2, p2, qx2;
  logic signed [34:0] rsxs2;
  logic clipn2, clipp2;

  assign dp_w   = xr1 * cfg.cos_theta;
  assign dsh    = dp_w[48:14];
  assign acp_w  = as1 * cfg.sin_theta;
  assign acsh   = acp_w[63:28];
  assign psh    = as1[47:14];
  assign qxsh   = xx1 >>> FRAC_BITS;
  assign rsxs_w = 35'(rs1) + 35'(xs1);
  assign d_s    = sat32(dsh);
  assign ac_s   = sat32(acsh);
  assign p_s    = sat32(psh);
  assign qx_s   = sat32(qxsh);

  always_ff @(posedge clk) begin
    if (en) begin
      d2     <= d_s.val;
      ac2    <= ac_s.val;
      p2     <= p_s.val;
      qx2    <= qx_s.val;
      rsxs2  <= rsxs_w;
      clipn2 <= d_s.clip | ac_s.clip | p_s.clip;
      clipp2 <= qx_s.clip;
    end
  end

  // stage 3: products
  logic signed [63:0] pd3, dd3, aqx3;
  logic signed [31:0] ac3;
  logic signed [34:0] rsxs3;
  logic clipn3, clipp3;

  always_ff @(posedge clk) begin
    if (en) begin
      pd3    <= p2 * d2;
      dd3    <= d2 * d2;
      aqx3   <= cfg.coef_a * qx2;
      ac3    <= ac2;
      rsxs3  <= rsxs2;
      clipn3 <= clipn2;
      clipp3 <= clipp2;
    end
  end

  // stage 4: B, Q and the pi/2 result
  logic signed [63:0] pdsh, ddsh, aqxsh;
  logic signed [65:0] pd2w, bbw, ypw;
  logic signed [31:0] cf_w, ce;
  sat_t bb_s, q_s, yp_s;
  logic signed [31:0] bb4, q4, yp4, ac4;
  logic signed [34:0] rsxs4;
  logic clipn4, clipp4;

  assign ce    = 32'(cfg.cos_theta);
  assign cf_w  = (FRAC_BITS >= 14) ? (ce <<< CF_L) : (ce >>> CF_R);
  assign pdsh  = pd3 >>> FRAC_BITS;
  assign pd2w  = 66'(pdsh) <<< 1;
  assign bbw   = -pd2w - 66'(cf_w);
  assign ddsh  = dd3 >>> FRAC_BITS;
  assign aqxsh = aqx3 >>> FRAC_BITS;
  assign ypw   = 66'(aqxsh) + 66'(cfg.coef_b) + 66'(cfg.radius);
  assign bb_s  = sat32(bbw);
  assign q_s   = sat32(ddsh);
  assign yp_s  = sat32(ypw);

  always_ff @(posedge clk) begin
    if (en) begin
      bb4    <= bb_s.val;
      q4     <= q_s.val;
      yp4    <= yp_s.val;
      ac4    <= ac3;
      rsxs4  <= rsxs3;
      clipn4 <= clipn3 | bb_s.clip | q_s.clip;
      clipp4 <= clipp3 | yp_s.clip;
    end
  end

  // stage 5: a*Q and B*B
  logic signed [63:0] aq5, bbsq5;
  logic signed [31:0] bb5, ac5, yp5;
  logic signed [34:0] rsxs5;
  logic clipn5, clipp5;

  always_ff @(posedge clk) begin
    if (en) begin
      aq5    <= cfg.coef_a * q4;
      bbsq5  <= bb4 * bb4;
      bb5    <= bb4;
      ac5    <= ac4;
      yp5    <= yp4;
      rsxs5  <= rsxs4;
      clipn5 <= clipn4;
      clipp5 <= clipp4;
    end
  end

  // stage 6: C
  logic signed [63:0] aqsh;
  logic signed [65:0] ccw;
  sat_t cc_s;
  logic signed [31:0] cc6, bb6, ac6, yp6;
  logic signed [61:0] bbq6;
  logic clipn6, clipp6;

  assign aqsh = aq5 >>> FRAC_BITS;
  assign ccw  = 66'(aqsh) + 66'(cfg.coef_b) - 66'(rsxs5);
  assign cc_s = sat32(ccw);

  always_ff @(posedge clk) begin
    if (en) begin
      cc6    <= cc_s.val;
      bbq6   <= bbsq5[63:2];
      bb6    <= bb5;
      ac6    <= ac5;
      yp6    <= yp5;
      clipn6 <= clipn5 | cc_s.clip;
      clipp6 <= clipp5;
    end
  end

  // stage 7: A*C
  logic signed [63:0] acc7;
  logic signed [61:0] bbq7;
  logic signed [31:0] bb7, ac7, yp7;
  logic clipn7, clipp7;

  always_ff @(posedge clk) begin
    if (en) begin
      acc7   <= ac6 * cc6;
      bbq7   <= bbq6;
      bb7    <= bb6;
      ac7    <= ac6;
      yp7    <= yp6;
      clipn7 <= clipn6;
      clipp7 <= clipp6;
    end
  end

  // stage 8: discriminant and early outcomes
  logic signed [64:0] ew;
  sq_side_t side_w;

  assign ew = 65'(bbq7) - 65'(acc7);

  always_comb begin
    side_w              = '0;
    side_w.bb           = bb7;
    side_w.ac           = ac7;
    side_w.base.y_early = '0;
    priority if (pi[7]) begin
      side_w.base.bypass  = 1'b1;
      side_w.base.y_early = yp7;
      side_w.base.st      = clipp7 ? ST_SAT : ST_OK;
    end else if (ac7 == '0) begin
      side_w.base.bypass = 1'b1;
      side_w.base.st     = ST_ZERO_A;
    end else if (ew[64]) begin
      side_w.base.bypass = 1'b1;
      side_w.base.st     = ST_NEG_DISC;
    end else begin
      side_w.base.bypass = 1'b0;
      side_w.base.st     = clipn7 ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rad  <= {1'b0, ew[62:0]};
      sq_side <= side_w;
    end
  end

  // valid and angle flag shift
  always_ff @(posedge clk) begin
    if (rst) begin
      v        <= '0;
      sq_valid <= 1'b0;
    end else if (en) begin
      v        <= {v[6:1], take};
      sq_valid <= v[7];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pi <= {pi[6:1], (cfg.cos_theta == '0) && !cfg.sin_theta[15] && (cfg.sin_theta != '0)};
    end
  end

endmodule

FILE: design/rlpi_sqrt_cell.sv
// rlpi_sqrt_cell: one restoring square-root step (one root bit per cell).
// Depends on rlpi_pkg.

module rlpi_sqrt_cell import rlpi_pkg::*; #(
  parameter int SW = $bits(sq_side_t)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                up_valid,
  input  logic [SQ_REM_W-1:0] up_rem,
  input  logic [ROOT_W-1:0]   up_root,
  input  logic [RAD_W-1:0]    up_rad,
  input  logic [SW-1:0]       up_side,
  output logic                dn_valid,
  output logic [SQ_REM_W-1:0] dn_rem,
  output logic [ROOT_W-1:0]   dn_root,
  output logic [RAD_W-1:0]    dn_rad,
  output logic [SW-1:0]       dn_side
);

  logic [SQ_REM_W-1:0] rem_t, trial;
  logic                hit;

  // bring down the next two radicand bits, try (4*root + 1)
  assign rem_t = {up_rem[SQ_REM_W-3:0], up_rad[RAD_W-1 -: 2]};
  assign trial = {1'b0, up_root, 2'b01};
  assign hit   = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      dn_rem  <= hit ? rem_t - trial : rem_t;
      dn_root <= {up_root[ROOT_W-2:0], hit};
      dn_rad  <= {up_rad[RAD_W-3:0], 2'b00};
      dn_side <= up_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= up_valid;
    end
  end

endmodule

FILE: design/rlpi_div_cell.sv
// rlpi_div_cell: one restoring unsigned division step (one quotient bit).
// Depends on rlpi_pkg.

module rlpi_div_cell import rlpi_pkg::*; #(
  parameter int SW = $bits(side_t)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 up_valid,
  input  logic [DIV_REM_W-1:0] up_rem,
  input  logic [Q_W-1:0]       up_lo,
  input  logic [Q_W-1:0]       up_q,
  input  logic [DEN_W-1:0]     up_den,
  input  logic [SW-1:0]        up_side,
  output logic                 dn_valid,
  output logic [DIV_REM_W-1:0] dn_rem,
  output logic [Q_W-1:0]       dn_lo,
  output logic [Q_W-1:0]       dn_q,
  output logic [DEN_W-1:0]     dn_den,
  output logic [SW-1:0]        dn_side
);

  logic [DIV_REM_W:0] rem_t, diff;
  logic               hit;

  assign rem_t = {up_rem, up_lo[Q_W-1]};
  assign diff  = rem_t - {1'b0, up_den};
  assign hit   = rem_t >= {1'b0, up_den};

  always_ff @(posedge clk) begin
    if (en) begin
      dn_rem  <= hit ? diff[DIV_REM_W-1:0] : rem_t[DIV_REM_W-1:0];
      dn_lo   <= {up_lo[Q_W-2:0], 1'b0};
      dn_q    <= {up_q[Q_W-2:0], hit};
      dn_den  <= up_den;
      dn_side <= up_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= up_valid;
    end
  end

endmodule

FILE: design/rotated_line_parabola_intersect.sv
// rotated_line_parabola_intersect: top level. Config registers, the front end,
// a 32-cell square-root chain, divider prep, a 32-cell divider chain, output skid.
// Depends on rlpi_pkg, rlpi_front, rlpi_sqrt_cell, rlpi_div_cell.
//
//   channel   handshake                  payload
//   -------   -------------------------  ---------------------------
//   in        in_valid / in_ready        x_pos
//   out       out_valid / out_ready      y_value, status
//   cfg       cfg_we (no wait)           cfg_index, cfg_data
//
// One beat per cycle in both directions while the skid is empty. An accepted
// input beat reaches the output register through 8 front stages, 32 sqrt
// cells, 3 divider prep stages, 32 divider cells and the output register.
// The whole pipeline advances together; it freezes only while the one-entry
// skid behind the output register is occupied, so in_ready is the inverted skid flag.
// Synchronous reset clears valid bits and loads register defaults
// (cos_theta = 1.0, everything else zero). No clearing pass.

module rotated_line_parabola_intersect import rlpi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input beats
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] x_pos,
  // result beats
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] y_value,
  output logic [1:0]         status,
  // configuration writes
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int NUMW = 34 + FRAC_BITS;              // |2S - B| * 2^F
  localparam int CMPW = (NUMW > 65) ? NUMW : 65;     // overflow compare width

  // ---------------------------------------------------------------------------
  // Config regs: user writes only while pipeline is empty; block does not check.
  // ---------------------------------------------------------------------------
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius    <= '0;
      cfg.cos_theta <= 16'sd16384;
      cfg.sin_theta <= '0;
      cfg.coef_a    <= '0;
      cfg.coef_b    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS: cfg.radius    <= cfg_data;
        REG_COS:    cfg.cos_theta <= cfg_data[15:0];
        REG_SIN:    cfg.sin_theta <= cfg_data[15:0];
        REG_COEF_A: cfg.coef_a    <= cfg_data;
        REG_COEF_B: cfg.coef_b    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline enable: everything moves unless the skid holds a result.
  // ---------------------------------------------------------------------------
  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign in_ready = !skid_valid;

  // ---------------------------------------------------------------------------
  // Front end: D, A, B, C, E and the early outcomes (pi/2, zero A, E < 0).
  // ---------------------------------------------------------------------------
  logic                sq_v    [0:ROOT_W];
  logic [SQ_REM_W-1:0] sq_rem  [0:ROOT_W];
  logic [ROOT_W-1:0]   sq_root [0:ROOT_W];
  logic [RAD_W-1:0]    sq_rad  [0:ROOT_W];
  sq_side_t            sq_side [0:ROOT_W];

  rlpi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .take     (in_valid && in_ready),
    .x_pos    (x_pos),
    .cfg      (cfg),
    .sq_valid (sq_v[0]),
    .sq_rad   (sq_rad[0]),
    .sq_side  (sq_side[0])
  );

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  // ---------------------------------------------------------------------------
  // Square-root chain: floor(sqrt(E)), one root bit per cell.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    rlpi_sqrt_cell #(.SW($bits(sq_side_t))) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .up_valid (sq_v[k]),
      .up_rem   (sq_rem[k]),
      .up_root  (sq_root[k]),
      .up_rad   (sq_rad[k]),
      .up_side  (sq_side[k]),
      .dn_valid (sq_v[k+1]),
      .dn_rem   (sq_rem[k+1]),
      .dn_root  (sq_root[k+1]),
      .dn_rad   (sq_rad[k+1]),
      .dn_side  (sq_side[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Divider prep. Quotient = trunc((2S - B) * 2^F / (2A)), done on magnitudes.
  // A: numerator 2S - B and |2A|.
  // ---------------------------------------------------------------------------
  sq_side_t           last_sq;
  logic               va;
  logic signed [33:0] n2a;
  logic [DEN_W-1:0]   dena;
  logic               acsa;
  side_t              sda;
  logic [31:0]        ac_abs;

  assign last_sq = sq_side[ROOT_W];
  assign ac_abs  = last_sq.ac[31] ? 32'(-last_sq.ac) : 32'(last_sq.ac);

  always_ff @(posedge clk) begin
    if (en) begin
      n2a  <= $signed({1'b0, sq_root[ROOT_W], 1'b0}) - 34'(last_sq.bb);
      dena <= {ac_abs, 1'b0};
      acsa <= last_sq.ac[31];
      sda  <= last_sq.base;
    end
  end

  // B: numerator magnitude and quotient sign
  logic             vb;
  logic [33:0]      n2b;
  logic [DEN_W-1:0] denb;
  side_t            sdb, sdb_w;

  always_comb begin
    sdb_w     = sda;
    sdb_w.neg = n2a[33] ^ acsa;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2b  <= n2a[33] ? 34'(-n2a) : 34'(n2a);
      denb <= dena;
      sdb  <= sdb_w;
    end
  end

  // C: overflow check (quotient >= 2^32) and first partial remainder
  logic [NUMW-1:0] num_w;
  logic [CMPW-1:0] lhs_w, rhs_w;
  side_t           sdc_w;

  assign num_w = {n2b, {FRAC_BITS{1'b0}}};
  assign lhs_w = CMPW'(num_w);
  assign rhs_w = CMPW'({denb, 32'b0});

  always_comb begin
    sdc_w     = sdb;
    sdc_w.ovf = lhs_w >= rhs_w;
  end

  logic                 dv   [0:Q_W];
  logic [DIV_REM_W-1:0] drem [0:Q_W];
  logic [Q_W-1:0]       dlo  [0:Q_W];
  logic [Q_W-1:0]       dq   [0:Q_W];
  logic [DEN_W-1:0]     dden [0:Q_W];
  side_t                dsd  [0:Q_W];

  always_ff @(posedge clk) begin
    if (en) begin
      drem[0] <= DIV_REM_W'(num_w[NUMW-1:32]);
      dlo[0]  <= num_w[31:0];
      dden[0] <= denb;
      dsd[0]  <= sdc_w;
    end
  end

  assign dq[0] = '0;

  // valid bits of the prep stages
  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= 1'b0;
      vb    <= 1'b0;
      dv[0] <= 1'b0;
    end else if (en) begin
      va    <= sq_v[ROOT_W];
      vb    <= va;
      dv[0] <= vb;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider chain: one quotient bit per cell.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < Q_W; k++) begin : g_div
    rlpi_div_cell #(.SW($bits(side_t))) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .up_valid (dv[k]),
      .up_rem   (drem[k]),
      .up_lo    (dlo[k]),
      .up_q     (dq[k]),
      .up_den   (dden[k]),
      .up_side  (dsd[k]),
      .dn_valid (dv[k+1]),
      .dn_rem   (drem[k+1]),
      .dn_lo    (dlo[k+1]),
      .dn_q     (dq[k+1]),
      .dn_den   (dden[k+1]),
      .dn_side  (dsd[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Final result: apply sign, saturate, merge status.
  // ---------------------------------------------------------------------------
  side_t              fs;
  logic [Q_W-1:0]     fq;
  logic               fclip;
  logic signed [31:0] fy_div, fin_y;
  logic [1:0]         fin_st;

  assign fs = dsd[Q_W];
  assign fq = dq[Q_W];

  always_comb begin
    fclip  = 1'b0;
    fy_div = '0;
    priority if (fs.ovf) begin
      fclip  = 1'b1;
      fy_div = fs.neg ? INT32_MIN : INT32_MAX;
    end else if (!fs.neg) begin
      if (fq[Q_W-1]) begin
        fclip  = 1'b1;
        fy_div = INT32_MAX;
      end else begin
        fy_div = fq;
      end
    end else begin
      if (fq > 32'h8000_0000) begin
        fclip  = 1'b1;
        fy_div = INT32_MIN;
      end else begin
        fy_div = -fq;
      end
    end

    if (fs.bypass) begin
      fin_y  = fs.y_early;
      fin_st = fs.st;
    end else begin
      fin_y  = fy_div;
      fin_st = (fs.st == ST_SAT || fclip) ? ST_SAT : ST_OK;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register plus one-entry skid. A beat leaving the pipeline while the
  // output register is blocked lands in the skid, which then freezes the chain.
  // ---------------------------------------------------------------------------
  logic signed [31:0] skid_y;
  logic [1:0]         skid_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        y_value    <= skid_y;
        status     <= skid_st;
        skid_valid <= 1'b0;
      end
    end else if (dv[Q_W]) begin
      if (!out_valid || out_ready) begin
        y_value   <= fin_y;
        status    <= fin_st;
        out_valid <= 1'b1;
      end else begin
        skid_y     <= fin_y;
        skid_st    <= fin_st;
        skid_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
